/* design/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and codes of the page frame allocator
// Request and response payloads, action and status codes, and the control
// bundle that the operation decoder hands back to the sequencer.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int PAGE_IN_W = 10;
  localparam int CFG_W     = 11;
  localparam int REF_OUT_W = 16;

  localparam logic [2:0] ACT_INIT   = 3'd0;
  localparam logic [2:0] ACT_ALLOC  = 3'd1;
  localparam logic [2:0] ACT_FREE   = 3'd2;
  localparam logic [2:0] ACT_INCREF = 3'd3;
  localparam logic [2:0] ACT_DECREF = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_RULE  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic CFG_TOTAL    = 1'b0;
  localparam logic CFG_RESERVED = 1'b1;

  localparam logic [CFG_W-1:0] TOTAL_RESET    = 11'd1024;
  localparam logic [CFG_W-1:0] RESERVED_RESET = 11'd0;

  typedef struct packed {
    logic [2:0]           action;
    logic [PAGE_IN_W-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [PAGE_IN_W-1:0] granted_page;
    logic [REF_OUT_W-1:0] ref_after;
    logic                 released;
  } rsp_t;

  typedef struct packed {
    logic [1:0] status;
    logic       wr_ref;
    logic       flag_next;
    logic       push;
    logic       pop;
    logic       released;
  } ctl_t;

endpackage

/* design/pfa_ram.sv */
// ----------------------------------------------------------------------------
// pfa_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/pfa_exec.sv */
// ----------------------------------------------------------------------------
// pfa_exec: operation decoder of the page frame allocator
// Given the action and the entry read from the count memory, decides the
// status, the new count and flag, and whether the free stack is pushed or
// popped.
// ----------------------------------------------------------------------------
module pfa_exec #(
  parameter int REF_BITS = 16
) (
  input  logic [2:0]                   action,
  input  logic                         page_oob,
  input  logic                         stack_empty,
  input  logic                         stack_full,
  input  logic [REF_BITS-1:0]          cnt,
  input  logic                         flag,
  output pfa_pkg::ctl_t                ctl,
  output logic [REF_BITS-1:0]          cnt_next,
  output logic [pfa_pkg::REF_OUT_W-1:0] ref_after
);

  logic [REF_BITS-1:0] cnt_out;
  logic [31:0]         cnt_wide;

  always_comb begin
    ctl           = '0;
    ctl.status    = pfa_pkg::ST_OK;
    ctl.flag_next = flag;
    cnt_next      = cnt;
    cnt_out       = '0;
    unique case (action)
      pfa_pkg::ACT_ALLOC: begin
        if (stack_empty) begin
          ctl.status = pfa_pkg::ST_NOMEM;
        end else begin
          ctl.pop       = 1'b1;
          ctl.wr_ref    = 1'b1;
          ctl.flag_next = 1'b0;
          cnt_out       = cnt;
        end
      end
      pfa_pkg::ACT_FREE: begin
        if (page_oob) begin
          ctl.status = pfa_pkg::ST_RANGE;
        end else begin
          cnt_out = cnt;
          if (flag || (cnt != '0)) begin
            ctl.status = pfa_pkg::ST_RULE;
          end else if (!stack_full) begin
            ctl.push      = 1'b1;
            ctl.wr_ref    = 1'b1;
            ctl.flag_next = 1'b1;
          end
        end
      end
      pfa_pkg::ACT_INCREF: begin
        if (page_oob) begin
          ctl.status = pfa_pkg::ST_RANGE;
        end else begin
          // The count saturates at its largest value.
          if (cnt != '1) begin
            cnt_next = cnt + REF_BITS'(1);
          end
          ctl.wr_ref = 1'b1;
          cnt_out    = cnt_next;
        end
      end
      pfa_pkg::ACT_DECREF: begin
        if (page_oob) begin
          ctl.status = pfa_pkg::ST_RANGE;
        end else if (cnt == '0) begin
          ctl.status = pfa_pkg::ST_RULE;
        end else begin
          cnt_next   = cnt - REF_BITS'(1);
          ctl.wr_ref = 1'b1;
          cnt_out    = cnt_next;
          if (cnt_next == '0) begin
            // A page that is already listed is not pushed a second time.
            if (flag) begin
              ctl.status = pfa_pkg::ST_RULE;
            end else begin
              ctl.released = 1'b1;
              if (!stack_full) begin
                ctl.push      = 1'b1;
                ctl.flag_next = 1'b1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign cnt_wide  = 32'(cnt_out);
  assign ref_after = cnt_wide[pfa_pkg::REF_OUT_W-1:0];

endmodule

/* design/page_frame_allocator_refcount.sv */
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount: page frame allocator with reference counts
// Keeps a LIFO stack of free pages and a count and free-list flag per page.
// ----------------------------------------------------------------------------
// Usage:
// A request (action, page_number) enters on req_valid/req_ready; one response
// (status, granted_page, ref_after, released) leaves on rsp_valid/rsp_ready
// for every request. Requests are handled one at a time. Each one does a
// read-modify-write of the per-page count memory, whose registered read sets
// the pace: free, incref, decref, unknown actions and an alloc from an empty
// stack read the count and then finish, a successful alloc reads the stack,
// then the count, then finishes, and init writes every entry of the count
// memory and each free page into the stack, one entry per cycle.
// The response sits in an output register; a new request is taken while it
// waits, and only the final write-back cycle of that request holds until the
// receiver takes the earlier response.
// After reset the block runs a clearing pass over every entry of the count
// memory with req_ready low; the stack is then empty. The cfg_we port
// writes total_pages (index 0) or reserved_pages (index 1) at once; the
// user must make writes only while the block is idle, which the block does
// not enforce. An init request must be issued before pages can be allocated.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount #(
  parameter int MAX_PAGES = 1024,
  parameter int REF_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  pfa_pkg::req_t            req,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output pfa_pkg::rsp_t            rsp,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [pfa_pkg::CFG_W-1:0] cfg_data
);

  localparam int PAGE_W  = $clog2(MAX_PAGES);
  localparam int DEPTH_W = PAGE_W + 1;
  localparam int CMP_W   = (PAGE_W + 1 > pfa_pkg::CFG_W) ? PAGE_W + 1 : pfa_pkg::CFG_W;
  localparam int ENTRY_W = REF_BITS + 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_POP   = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0]                state;
  logic [pfa_pkg::CFG_W-1:0] total_pages;
  logic [pfa_pkg::CFG_W-1:0] reserved_pages;
  logic [pfa_pkg::CFG_W-1:0] eff_total;
  logic [pfa_pkg::CFG_W-1:0] eff_res;
  logic [pfa_pkg::CFG_W-1:0] sw_total;
  logic [pfa_pkg::CFG_W-1:0] sw_res;
  logic                      sw_reply;
  logic [PAGE_W-1:0]         idx;
  logic [DEPTH_W-1:0]        depth;
  logic [2:0]                act;
  logic [pfa_pkg::PAGE_IN_W-1:0] page;
  logic [PAGE_W-1:0]         page_idx;
  logic [PAGE_W-1:0]         pop_page;

  logic                      req_fire;
  logic                      advance;
  logic                      page_oob;
  logic                      sw_free;
  logic                      sw_used;
  logic                      idx_last;

  logic                      ref_we;
  logic [PAGE_W-1:0]         ref_waddr;
  logic [ENTRY_W-1:0]        ref_wdata;
  logic                      ref_re;
  logic [PAGE_W-1:0]         ref_raddr;
  logic [ENTRY_W-1:0]        ref_rdata;

  logic                      stk_we;
  logic [PAGE_W-1:0]         stk_waddr;
  logic [PAGE_W-1:0]         stk_wdata;
  logic                      stk_re;
  logic [PAGE_W-1:0]         stk_raddr;
  logic [PAGE_W-1:0]         stk_rdata;

  pfa_pkg::ctl_t             ctl;
  logic [REF_BITS-1:0]       cnt_next;
  logic [pfa_pkg::REF_OUT_W-1:0] ref_after;

  // Effective limits: the total is capped at the memory size and the
  // reserved count at the total.
  assign eff_total = (CMP_W'(total_pages) > CMP_W'(MAX_PAGES)) ?
                     pfa_pkg::CFG_W'(MAX_PAGES) : total_pages;
  assign eff_res   = (reserved_pages > eff_total) ? eff_total : reserved_pages;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign advance   = (state == S_EXEC) && (!rsp_valid || rsp_ready);
  assign page_idx  = PAGE_W'(page);
  assign page_oob  = ({1'b0, page} >= eff_total);

  assign sw_used  = CMP_W'(idx) < CMP_W'(sw_res);
  assign sw_free  = !sw_used && (CMP_W'(idx) < CMP_W'(sw_total));
  assign idx_last = (idx == PAGE_W'(MAX_PAGES - 1));

  pfa_exec #(
    .REF_BITS (REF_BITS)
  ) u_exec (
    .action      (act),
    .page_oob    (page_oob),
    .stack_empty (depth == '0),
    .stack_full  (depth == DEPTH_W'(MAX_PAGES)),
    .cnt         (ref_rdata[REF_BITS-1:0]),
    .flag        (ref_rdata[REF_BITS]),
    .ctl         (ctl),
    .cnt_next    (cnt_next),
    .ref_after   (ref_after)
  );

  always_comb begin
    ref_re    = 1'b0;
    ref_raddr = PAGE_W'(req.page_number);
    stk_re    = 1'b0;
    stk_raddr = PAGE_W'(depth - DEPTH_W'(1));
    if (state == S_IDLE) begin
      ref_re = req_fire;
      stk_re = req_fire;
    end else if (state == S_POP) begin
      ref_re    = 1'b1;
      ref_raddr = stk_rdata;
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      ref_we    = 1'b1;
      ref_waddr = idx;
      ref_wdata = {sw_free, (sw_used ? REF_BITS'(1) : REF_BITS'(0))};
      stk_we    = sw_free;
      stk_waddr = PAGE_W'(CMP_W'(idx) - CMP_W'(sw_res));
      stk_wdata = idx;
    end else begin
      ref_we    = advance && ctl.wr_ref;
      ref_waddr = (act == pfa_pkg::ACT_ALLOC) ? pop_page : page_idx;
      ref_wdata = {ctl.flag_next, cnt_next};
      stk_we    = advance && ctl.push;
      stk_waddr = depth[PAGE_W-1:0];
      stk_wdata = page_idx;
    end
  end

  pfa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PAGES)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (ref_wdata),
    .re    (ref_re),
    .raddr (ref_raddr),
    .rdata (ref_rdata)
  );

  pfa_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (MAX_PAGES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages    <= pfa_pkg::TOTAL_RESET;
      reserved_pages <= pfa_pkg::RESERVED_RESET;
    end else if (cfg_we) begin
      if (cfg_index == pfa_pkg::CFG_TOTAL) begin
        total_pages <= cfg_data;
      end else begin
        reserved_pages <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      sw_total  <= '0;
      sw_res    <= '0;
      sw_reply  <= 1'b0;
      depth     <= '0;
      rsp_valid <= 1'b0;
      act       <= pfa_pkg::ACT_INIT;
    end else begin
      if (rsp_valid && rsp_ready && !advance) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (idx_last) begin
            idx   <= '0;
            state <= sw_reply ? S_EXEC : S_IDLE;
          end else begin
            idx <= idx + PAGE_W'(1);
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            act  <= req.action;
            page <= req.page_number;
            if (req.action == pfa_pkg::ACT_INIT) begin
              sw_total <= eff_total;
              sw_res   <= eff_res;
              sw_reply <= 1'b1;
              idx      <= '0;
              state    <= S_CLEAR;
            end else if (req.action == pfa_pkg::ACT_ALLOC && depth != '0) begin
              state <= S_POP;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_POP: begin
          pop_page <= stk_rdata;
          state    <= S_EXEC;
        end
        S_EXEC: begin
          if (advance) begin
            rsp_valid        <= 1'b1;
            rsp.status       <= ctl.status;
            rsp.granted_page <= ctl.pop ? pfa_pkg::PAGE_IN_W'(pop_page) : '0;
            rsp.ref_after    <= ref_after;
            rsp.released     <= ctl.released;
            if (act == pfa_pkg::ACT_INIT) begin
              depth <= DEPTH_W'(sw_total - sw_res);
            end else if (ctl.push) begin
              depth <= depth + DEPTH_W'(1);
            end else if (ctl.pop) begin
              depth <= depth - DEPTH_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The stack never holds more pages than exist.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(MAX_PAGES))
    else $error("free stack depth exceeds page count");

  // Memories are only written during a sweep or a write-back.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_POP) |-> (!ref_we && !stk_we))
    else $error("memory write outside sweep or write-back");

  // A released page always reports a clean result with a zero count.
  a_release_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.released) |-> (rsp.status == pfa_pkg::ST_OK && rsp.ref_after == '0))
    else $error("released page with bad status or count");

  // A page is granted only by a successful pop, which changes the depth.
  a_pop_depth: assert property (@(posedge clk) disable iff (rst)
    (advance && ctl.pop) |=> (depth == $past(depth) - DEPTH_W'(1)))
    else $error("pop did not shrink the free stack");

endmodule

/* test/page_frame_allocator_refcount_tb.sv */
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount_tb: testbench of the page frame allocator
// Sends alloc, free, incref, decref, init and unknown requests under several
// page and reservation settings. Every response is checked against the
// bench's own software image of the free stack and the page counts.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PAGES   = 1024;
  localparam int unsigned REF_BITS    = 16;
  localparam int unsigned REF_LIMIT   = (1 << REF_BITS) - 1;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      req_valid = 1'b0;
  logic                      req_ready;
  pfa_pkg::req_t             req = '0;
  logic                      rsp_valid;
  logic                      rsp_ready = 1'b0;
  pfa_pkg::rsp_t             rsp;
  logic                      cfg_we = 1'b0;
  logic                      cfg_index = pfa_pkg::CFG_TOTAL;
  logic [pfa_pkg::CFG_W-1:0] cfg_data = '0;

  // Software image of the allocator.
  logic [pfa_pkg::CFG_W-1:0]     cfg_total = pfa_pkg::TOTAL_RESET;
  logic [pfa_pkg::CFG_W-1:0]     cfg_reserved = pfa_pkg::RESERVED_RESET;
  int unsigned                   page_refs [MAX_PAGES];
  bit                            on_list [MAX_PAGES];
  logic [pfa_pkg::PAGE_IN_W-1:0] free_pages [MAX_PAGES];
  int unsigned                   free_count = 0;

  pfa_pkg::rsp_t                 due_responses [$];
  logic [pfa_pkg::PAGE_IN_W-1:0] last_page = '0;
  bit                            gaps_on = 1'b1;
  int                            mismatches = 0;
  int                            cycles = 0;
  int                            stall_left = 0;

  page_frame_allocator_refcount #(
    .MAX_PAGES(MAX_PAGES),
    .REF_BITS (REF_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned managed_pages();
    return (cfg_total > MAX_PAGES) ? MAX_PAGES : cfg_total;
  endfunction

  function automatic void push_free(int unsigned p);
    if (free_count < MAX_PAGES) begin
      free_pages[free_count] = p[pfa_pkg::PAGE_IN_W-1:0];
      free_count++;
      on_list[p] = 1'b1;
    end
  endfunction

  function automatic pfa_pkg::rsp_t allocator_step(logic [2:0] action,
                                                   logic [pfa_pkg::PAGE_IN_W-1:0] page);
    pfa_pkg::rsp_t o;
    int unsigned   total;
    int unsigned   held;
    int unsigned   p;
    o = '0;
    total = managed_pages();
    p = page;
    case (action)
      pfa_pkg::ACT_INIT: begin
        held = (cfg_reserved > total) ? total : cfg_reserved;
        free_count = 0;
        for (int unsigned i = 0; i < MAX_PAGES; i++) begin
          page_refs[i] = (i < held) ? 1 : 0;
          on_list[i] = 1'b0;
        end
        for (int unsigned i = held; i < total; i++) push_free(i);
      end
      pfa_pkg::ACT_ALLOC: begin
        if (free_count == 0) begin
          o.status = pfa_pkg::ST_NOMEM;
        end else begin
          free_count--;
          p = free_pages[free_count];
          on_list[p] = 1'b0;
          o.granted_page = p[pfa_pkg::PAGE_IN_W-1:0];
          o.ref_after = page_refs[p][pfa_pkg::REF_OUT_W-1:0];
        end
      end
      pfa_pkg::ACT_FREE, pfa_pkg::ACT_INCREF, pfa_pkg::ACT_DECREF: begin
        if (p >= total) begin
          o.status = pfa_pkg::ST_RANGE;
        end else begin
          case (action)
            pfa_pkg::ACT_FREE: begin
              if (on_list[p] || page_refs[p] != 0) o.status = pfa_pkg::ST_RULE;
              else push_free(p);
            end
            pfa_pkg::ACT_INCREF: begin
              if (page_refs[p] < REF_LIMIT) page_refs[p]++;
            end
            default: begin
              if (page_refs[p] == 0) begin
                o.status = pfa_pkg::ST_RULE;
              end else begin
                page_refs[p]--;
                // A page that reaches zero while still listed is not pushed twice.
                if (page_refs[p] == 0) begin
                  if (on_list[p]) begin
                    o.status = pfa_pkg::ST_RULE;
                  end else begin
                    push_free(p);
                    o.released = 1'b1;
                  end
                end
              end
            end
          endcase
          o.ref_after = page_refs[p][pfa_pkg::REF_OUT_W-1:0];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic pfa_pkg::req_t random_request();
    pfa_pkg::req_t r;
    int unsigned   roll;
    r.page_number = pfa_pkg::PAGE_IN_W'($urandom_range(0, MAX_PAGES - 1));
    roll = $urandom_range(0, 99);
    if (roll < 3) r.action = pfa_pkg::ACT_INIT;
    else if (roll < 6) r.action = 3'(pfa_pkg::ACT_DECREF + $urandom_range(1, 3));
    else if (roll < 35) r.action = pfa_pkg::ACT_ALLOC;
    else if (roll < 50) r.action = pfa_pkg::ACT_FREE;
    else if (roll < 70) r.action = pfa_pkg::ACT_INCREF;
    else r.action = pfa_pkg::ACT_DECREF;
    // Mostly work on the page just handed out or on managed pages.
    roll = $urandom_range(0, 99);
    if (roll < 40) r.page_number = last_page;
    else if (roll < 90)
      r.page_number = pfa_pkg::PAGE_IN_W'($urandom_range(0, managed_pages() - 1));
    return r;
  endfunction

  // Valid stays high after acceptance; the next request or a gap replaces it.
  task automatic send_request(input logic [2:0] action,
                              input logic [pfa_pkg::PAGE_IN_W-1:0] page);
    pfa_pkg::rsp_t want;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req <= '{action: action, page_number: page};
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    want = allocator_step(action, page);
    if (action == pfa_pkg::ACT_ALLOC && want.status == pfa_pkg::ST_OK)
      last_page = want.granted_page;
    due_responses.push_back(want);
  endtask

  task automatic send_random(input int count);
    pfa_pkg::req_t r;
    repeat (count) begin
      r = random_request();
      send_request(r.action, r.page_number);
    end
  endtask

  task automatic drain_responses();
    req_valid <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reconfigure(input int unsigned total, input int unsigned reserved);
    drain_responses();
    cfg_we <= 1'b1;
    cfg_index <= pfa_pkg::CFG_TOTAL;
    cfg_data <= pfa_pkg::CFG_W'(total);
    @(posedge clk);
    cfg_index <= pfa_pkg::CFG_RESERVED;
    cfg_data <= pfa_pkg::CFG_W'(reserved);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_total = pfa_pkg::CFG_W'(total);
    cfg_reserved = pfa_pkg::CFG_W'(reserved);
  endtask

  task automatic test_directed();
    send_request(pfa_pkg::ACT_ALLOC, 10'h3FF);
    reconfigure(8, 2);
    send_request(pfa_pkg::ACT_INIT, 10'd0);
    send_request(pfa_pkg::ACT_ALLOC, 10'd0);
    send_request(pfa_pkg::ACT_INCREF, 10'd7);
    send_request(pfa_pkg::ACT_INCREF, 10'd7);
    send_request(pfa_pkg::ACT_FREE, 10'd7);
    send_request(pfa_pkg::ACT_DECREF, 10'd7);
    send_request(pfa_pkg::ACT_DECREF, 10'd7);
    send_request(pfa_pkg::ACT_FREE, 10'd7);
    send_request(pfa_pkg::ACT_DECREF, 10'd7);
    send_request(pfa_pkg::ACT_INCREF, 10'd6);
    send_request(pfa_pkg::ACT_DECREF, 10'd6);
    send_request(pfa_pkg::ACT_FREE, 10'd0);
    send_request(pfa_pkg::ACT_DECREF, 10'd0);
    send_request(pfa_pkg::ACT_INCREF, 10'd8);
    send_request(pfa_pkg::ACT_DECREF, 10'h3FF);
    send_request(pfa_pkg::ACT_FREE, 10'h200);
    send_request(3'(pfa_pkg::ACT_DECREF + 1), 10'h3FF);
    send_request(3'(pfa_pkg::ACT_DECREF + 2), 10'd0);
    send_request(3'(pfa_pkg::ACT_DECREF + 3), 10'h155);
    repeat (8) send_request(pfa_pkg::ACT_ALLOC, 10'h2AA);
  endtask

  task automatic test_config_extremes();
    int unsigned totals [6] = '{1024, 2047, 1, 1024, 2047, 1};
    int unsigned holds [6]  = '{0, 2047, 0, 1024, 3, 1};
    for (int i = 0; i < 6; i++) begin
      reconfigure(totals[i], holds[i]);
      send_request(pfa_pkg::ACT_INIT,
                   pfa_pkg::PAGE_IN_W'($urandom_range(0, MAX_PAGES - 1)));
      send_random(10);
    end
  endtask

  task automatic test_refcount_run();
    gaps_on = 1'b0;
    reconfigure(4, 0);
    send_request(pfa_pkg::ACT_INIT, 10'd0);
    repeat (20) send_request(pfa_pkg::ACT_INCREF, 10'd2);
    send_request(pfa_pkg::ACT_DECREF, 10'd2);
    send_request(pfa_pkg::ACT_FREE, 10'd2);
  endtask

  task automatic test_random_phases();
    int unsigned total;
    for (int ph = 0; ph < 12; ph++) begin
      gaps_on = (ph < 10);
      total = ($urandom_range(0, 3) == 0) ? $urandom_range(25, MAX_PAGES)
                                          : $urandom_range(1, 24);
      reconfigure(total, $urandom_range(0, total + 3));
      // Every fourth phase keeps the old free stack under the new range.
      if (ph % 4 != 3)
        send_request(pfa_pkg::ACT_INIT,
                     pfa_pkg::PAGE_IN_W'($urandom_range(0, MAX_PAGES - 1)));
      for (int k = 0; k < 120; k++) begin
        if (ph == 4 && k == 60) drain_responses();
        send_random(1);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_extremes();
    test_refcount_run();
    test_random_phases();
    drain_responses();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk) begin : check_responses
    pfa_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (due_responses.size() == 0) begin
        mismatches++;
        $display("%0t: response with no request outstanding: %p", $time, rsp);
      end else begin
        want = due_responses.pop_front();
        if (rsp !== want) begin
          mismatches++;
          $display("%0t: mismatch, expected %p, actual %p", $time, want, rsp);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

/* page_frame_allocator_refcount.f */
design/pfa_pkg.sv
design/pfa_ram.sv
design/pfa_exec.sv
design/page_frame_allocator_refcount.sv
test/page_frame_allocator_refcount_tb.sv
